[rtl/ctsb_pkg.sv]
// ----------------------------------------------------------------------------
// ctsb_pkg
// Shared types, register indexes and dimension helpers for the sprite blitter.
// ----------------------------------------------------------------------------
package ctsb_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int DIM_W     = 11;
  localparam int COORD_W   = 10;
  localparam int OFFSET_W  = 12;
  localparam int PIXEL_W   = 16;
  localparam int SLOT_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_DEST_WIDTH    = 3'd4,
    REG_DEST_HEIGHT   = 3'd5,
    REG_USE_PALETTE   = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_x;
    logic [OFFSET_W-1:0] offset_y;
    logic [DIM_W-1:0]    source_width;
    logic [DIM_W-1:0]    source_height;
    logic [DIM_W-1:0]    dest_width;
    logic [DIM_W-1:0]    dest_height;
    logic                use_palette;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } place_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

[rtl/ctsb_geom.sv]
// ----------------------------------------------------------------------------
// ctsb_geom
// Source column and row counters, destination placement and clipping.
// ----------------------------------------------------------------------------
module ctsb_geom
  import ctsb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  cfg_t   cfg,
  output place_t place
);

  logic [COORD_W-1:0] column_count;
  logic [COORD_W-1:0] row_count;
  logic [COORD_W-1:0] column_count_next;
  logic [COORD_W-1:0] row_count_next;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic [COORD_W+2:0] tx;
  logic [COORD_W+2:0] ty;
  logic               in_x;
  logic               in_y;

  always_comb begin
    tx = {3'b000, column_count} + {cfg.offset_x[OFFSET_W-1], cfg.offset_x};
    ty = {3'b000, row_count} + {cfg.offset_y[OFFSET_W-1], cfg.offset_y};
    in_x = !tx[COORD_W+2] && (tx[COORD_W+1:0] < {1'b0, eff_dim(cfg.dest_width)});
    in_y = !ty[COORD_W+2] && (ty[COORD_W+1:0] < {1'b0, eff_dim(cfg.dest_height)});
    place.hit = in_x && in_y;
    place.x   = tx[COORD_W-1:0];
    place.y   = ty[COORD_W-1:0];
  end

  always_comb begin
    col_inc = {1'b0, column_count} + DIM_W'(1);
    row_inc = {1'b0, row_count} + DIM_W'(1);
    column_count_next = col_inc[COORD_W-1:0];
    row_count_next    = row_count;
    if (col_inc >= eff_dim(cfg.source_width)) begin
      column_count_next = '0;
      if (row_inc >= eff_dim(cfg.source_height)) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_inc[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

[rtl/ctsb_palette.sv]
// ----------------------------------------------------------------------------
// ctsb_palette
// Palette memory. Index reduction stage, then in-order write or registered read.
// ----------------------------------------------------------------------------
module ctsb_palette
  import ctsb_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               load,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [PIXEL_W-1:0] value,
  output logic [PIXEL_W-1:0] rd_data
);

  localparam int AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int SHIFT  = 24;
  localparam int RECIP_W = 24;
  localparam int PROD_W = PIXEL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + PALETTE_DEPTH - 1) / PALETTE_DEPTH);

  logic [PIXEL_W-1:0] mem [PALETTE_DEPTH];

  logic               s1_wr;
  logic [SLOT_W-1:0]  s1_slot;
  logic [PIXEL_W-1:0] s1_value;
  logic [PROD_W-1:0]  s1_prod;
  logic [PIXEL_W-1:0] quot;
  logic [PIXEL_W-1:0] rem;
  logic [AW-1:0]      rd_addr;
  logic               wr_ok;

  always_comb begin
    quot    = s1_prod[PROD_W-1:SHIFT];
    rem     = s1_value - PIXEL_W'(32'(quot) * 32'(PALETTE_DEPTH));
    rd_addr = rem[AW-1:0];
    wr_ok   = s1_wr && ({1'b0, s1_slot} < (SLOT_W+1)'(PALETTE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_wr <= 1'b0;
    end else if (adv) begin
      s1_wr <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_slot  <= slot;
      s1_value <= value;
      s1_prod  <= PROD_W'(value) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_ok) begin
        mem[s1_slot[AW-1:0]] <= s1_value;
      end
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/clipped_transparent_sprite_blitter.sv]
// ----------------------------------------------------------------------------
// clipped_transparent_sprite_blitter
// Sprite blitter with palette lookup, transparency and destination clipping.
//
// Input requests (mode, palette_slot, value) arrive on a valid/ready channel.
// A mode 0 request loads a palette entry; a mode 1 request is the next source
// pixel in raster order. Each pixel that is nonzero and lands inside the
// destination bounds produces one write request (dest_x, dest_y, colour) on
// the output valid/ready channel; other requests produce nothing.
// Throughput is one request per cycle while the output is not stalled. From
// input acceptance to output valid a request passes placement and index
// multiply, index reduction with the palette memory read, then the output
// register. Palette writes pass through the same stages, so loads and
// lookups reach the memory in order. When the output is stalled the whole
// pipeline holds and in_ready drops. Reset clears counters, configuration
// and pipeline valids; palette contents are undefined until loaded. Configure
// through cfg_we/cfg_index/cfg_data only while the block is idle.
// ----------------------------------------------------------------------------
module clipped_transparent_sprite_blitter
  import ctsb_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [SLOT_W-1:0]    palette_slot,
  input  logic [PIXEL_W-1:0]   value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   dest_x,
  output logic [COORD_W-1:0]   dest_y,
  output logic [PIXEL_W-1:0]   colour
);

  cfg_t   cfg;
  place_t place;
  logic   adv;
  logic   accept;

  logic               a_valid;
  logic [COORD_W-1:0] a_x;
  logic [COORD_W-1:0] a_y;
  logic [PIXEL_W-1:0] a_value;
  logic               b_valid;
  logic [COORD_W-1:0] b_x;
  logic [COORD_W-1:0] b_y;
  logic [PIXEL_W-1:0] b_value;
  logic [PIXEL_W-1:0] pal_data;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x      <= '0;
      cfg.offset_y      <= '0;
      cfg.source_width  <= DIM_W'(1);
      cfg.source_height <= DIM_W'(1);
      cfg.dest_width    <= DIM_W'(1);
      cfg.dest_height   <= DIM_W'(1);
      cfg.use_palette   <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_OFFSET_X:      cfg.offset_x      <= cfg_data;
        REG_OFFSET_Y:      cfg.offset_y      <= cfg_data;
        REG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= cfg_data[DIM_W-1:0];
        REG_DEST_WIDTH:    cfg.dest_width    <= cfg_data[DIM_W-1:0];
        REG_DEST_HEIGHT:   cfg.dest_height   <= cfg_data[DIM_W-1:0];
        REG_USE_PALETTE:   cfg.use_palette   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ctsb_geom u_geom (
    .clk   (clk),
    .rst   (rst),
    .step  (accept && mode),
    .cfg   (cfg),
    .place (place)
  );

  ctsb_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .load    (accept && !mode),
    .slot    (palette_slot),
    .value   (value),
    .rd_data (pal_data)
  );

  // advance the pipeline whenever the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= accept && mode && place.hit && (value != '0);
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x     <= place.x;
      a_y     <= place.y;
      a_value <= value;
      b_x     <= a_x;
      b_y     <= a_y;
      b_value <= a_value;
      dest_x  <= b_x;
      dest_y  <= b_y;
      colour  <= cfg.use_palette ? pal_data : b_value;
    end
  end

endmodule
